// ===== hdl/polygon_plane_coefficients_core_macros.svh =====
// Assertion macros shared by the RTL of the plane coefficient core.
`ifndef POLYGON_PLANE_COEFFICIENTS_CORE_MACROS_SVH
`define POLYGON_PLANE_COEFFICIENTS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define PCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PCC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/pcc_pkg.sv =====
// Types and constants shared by the plane coefficient core.
`default_nettype none
package pcc_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int IN_COORD_W  = 16;
  localparam int IN_TDATA_W  = 3 * IN_COORD_W;
  localparam int SUM_W       = 45;
  localparam int D_W         = 63;
  localparam int LO_W        = 23;
  localparam int OUT_FIELD_W = 3 * SUM_W + D_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - OUT_FIELD_W;

  // One classified vertex as it travels from the front to the back end.
  typedef struct packed {
    logic [IN_COORD_W-1:0] x;
    logic [IN_COORD_W-1:0] y;
    logic [IN_COORD_W-1:0] z;
    logic                  first;
    logic                  last;
    logic                  ovf;
  } vtx_t;

  // Back end status seen by the top level.
  typedef struct packed {
    logic running;
    logic pop;
    logic emit;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_CLOSE,
    ST_FLUSH,
    ST_DMUL,
    ST_DACC,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/pcc_front.sv =====
// Front end: accepts vertices, tracks the vertex count and tags each vertex.
`default_nettype none
module pcc_front #(
  parameter int MAX_VERTICES = pcc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [pcc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          in_tlast,
  input  wire logic                          q_full,
  output logic                               q_push,
  output pcc_pkg::vtx_t                      q_entry
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             at_max;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign at_max    = (cnt_r >= CNT_W'(MAX_VERTICES));

  always_comb begin
    q_entry.x     = in_tdata[pcc_pkg::IN_COORD_W-1:0];
    q_entry.y     = in_tdata[2*pcc_pkg::IN_COORD_W-1:pcc_pkg::IN_COORD_W];
    q_entry.z     = in_tdata[3*pcc_pkg::IN_COORD_W-1:2*pcc_pkg::IN_COORD_W];
    q_entry.first = (cnt_r == '0);
    q_entry.last  = in_tlast;
    q_entry.ovf   = ovf_r || at_max;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_tlast) begin
        // polygon closes: start the next one fresh
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (at_max) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pcc_queue.sv =====
// Short vertex queue between the front and back ends.
`default_nettype none
module pcc_queue #(
  parameter int DEPTH = pcc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pcc_pkg::vtx_t push_entry,
  output logic               full,
  input  wire logic          pop,
  output pcc_pkg::vtx_t      pop_entry,
  output logic               valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcc_pkg::vtx_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign valid     = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pcc_back.sv =====
// Back end: edge sums, closing edge, offset term and the result register.
`default_nettype none
module pcc_back #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire pcc_pkg::vtx_t                   q_entry,
  output pcc_pkg::back_stat_t                  stat,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pcc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);

  localparam int CB    = COORD_BITS;
  localparam int EW    = CB + 1;
  localparam int PW    = 2 * EW;
  localparam int SW    = pcc_pkg::SUM_W;
  localparam int DW    = pcc_pkg::D_W;
  localparam int LW    = pcc_pkg::LO_W;
  localparam int MW    = LW + 1;
  localparam int PPW   = MW + CB;
  localparam int LAST_STEP = 5;

  pcc_pkg::back_state_t state_r, state_nxt;

  logic signed [CB-1:0] cx, cy, cz;
  logic signed [CB-1:0] fx_r, fy_r, fz_r;
  logic signed [CB-1:0] px_r, py_r, pz_r;
  logic signed [CB-1:0] jx, jy, jz;
  logic signed [EW-1:0] dx, dy, dz, sx, sy, sz;
  logic signed [PW-1:0] pa, pb, pc;
  logic signed [PW-1:0] prod_a_r, prod_b_r, prod_c_r;
  logic                 prod_v_r;
  logic signed [SW-1:0] sum_a_r, sum_b_r, sum_c_r;
  logic                 ovf_r;

  logic [2:0]           step_r;
  logic [SW-1:0]        s_sel;
  logic signed [CB-1:0] f_sel;
  logic signed [MW-1:0] mop;
  logic signed [PPW-1:0] pp, pp_r;
  logic                 pp_v_r, pp_hi_r;
  logic signed [DW-1:0] pp_ext, term;
  logic signed [DW-1:0] acc_r;

  logic out_valid_r;
  logic [pcc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic out_user_r;

  logic pop, edge_en, mul_en, emit, out_free;

  // Keep the low COORD_BITS of each coordinate as a signed value.
  always_comb begin
    logic [31:0] ex, ey, ez;
    ex = {16'b0, q_entry.x};
    ey = {16'b0, q_entry.y};
    ez = {16'b0, q_entry.z};
    cx = signed'(ex[CB-1:0]);
    cy = signed'(ey[CB-1:0]);
    cz = signed'(ez[CB-1:0]);
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcc_pkg::ST_RUN:   if (q_valid && q_entry.last) state_nxt = pcc_pkg::ST_CLOSE;
      pcc_pkg::ST_CLOSE: state_nxt = pcc_pkg::ST_FLUSH;
      pcc_pkg::ST_FLUSH: state_nxt = pcc_pkg::ST_DMUL;
      pcc_pkg::ST_DMUL:  if (step_r == 3'(LAST_STEP)) state_nxt = pcc_pkg::ST_DACC;
      pcc_pkg::ST_DACC:  state_nxt = pcc_pkg::ST_EMIT;
      pcc_pkg::ST_EMIT:  if (out_free) state_nxt = pcc_pkg::ST_RUN;
      default:           state_nxt = pcc_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    edge_en = 1'b0;
    mul_en  = 1'b0;
    emit    = 1'b0;
    unique case (state_r)
      pcc_pkg::ST_RUN: begin
        pop     = q_valid;
        edge_en = q_valid && !q_entry.first;
      end
      pcc_pkg::ST_CLOSE: edge_en = 1'b1;
      pcc_pkg::ST_FLUSH: ;
      pcc_pkg::ST_DMUL:  mul_en = 1'b1;
      pcc_pkg::ST_DACC:  ;
      pcc_pkg::ST_EMIT:  emit = out_free;
      default: ;
    endcase
  end

  assign stat.running = (state_r == pcc_pkg::ST_RUN);
  assign stat.pop     = pop;
  assign stat.emit    = emit;

  // Edge from the previous vertex to the new one, or back to the first.
  always_comb begin
    if (state_r == pcc_pkg::ST_CLOSE) begin
      jx = fx_r;
      jy = fy_r;
      jz = fz_r;
    end else begin
      jx = cx;
      jy = cy;
      jz = cz;
    end
    dx = EW'(px_r) - EW'(jx);
    dy = EW'(py_r) - EW'(jy);
    dz = EW'(pz_r) - EW'(jz);
    sx = EW'(px_r) + EW'(jx);
    sy = EW'(py_r) + EW'(jy);
    sz = EW'(pz_r) + EW'(jz);
    pa = dy * sz;
    pb = dz * sx;
    pc = dx * sy;
  end

  // Offset partial products: low and high half of each sum times a first coordinate.
  always_comb begin
    case (step_r[2:1])
      2'd0: begin
        s_sel = sum_a_r;
        f_sel = fx_r;
      end
      2'd1: begin
        s_sel = sum_b_r;
        f_sel = fy_r;
      end
      default: begin
        s_sel = sum_c_r;
        f_sel = fz_r;
      end
    endcase
    if (step_r[0]) begin
      mop = MW'(signed'(s_sel[SW-1:LW]));
    end else begin
      mop = signed'({1'b0, s_sel[LW-1:0]});
    end
    pp     = mop * f_sel;
    pp_ext = DW'(pp_r);
    term   = pp_hi_r ? (pp_ext <<< LW) : pp_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcc_pkg::ST_RUN;
      prod_v_r    <= 1'b0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      sum_c_r     <= '0;
      step_r      <= '0;
      pp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prod_v_r <= edge_en;
      pp_v_r   <= mul_en;
      if (emit) begin
        sum_a_r <= '0;
        sum_b_r <= '0;
        sum_c_r <= '0;
      end else if (prod_v_r) begin
        sum_a_r <= sum_a_r + SW'(prod_a_r);
        sum_b_r <= sum_b_r + SW'(prod_b_r);
        sum_c_r <= sum_c_r + SW'(prod_c_r);
      end
      if (mul_en) begin
        step_r <= (step_r == 3'(LAST_STEP)) ? '0 : step_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_a_r <= pa;
    prod_b_r <= pb;
    prod_c_r <= pc;
    pp_r     <= pp;
    pp_hi_r  <= step_r[0];
    if (pop) begin
      px_r <= cx;
      py_r <= cy;
      pz_r <= cz;
      if (q_entry.first) begin
        fx_r <= cx;
        fy_r <= cy;
        fz_r <= cz;
      end
      if (q_entry.last) begin
        ovf_r <= q_entry.ovf;
      end
    end
    // subtract the partial products so the offset comes out negated
    if (state_r == pcc_pkg::ST_FLUSH) begin
      acc_r <= '0;
    end else if (pp_v_r) begin
      acc_r <= acc_r - term;
    end
    if (emit) begin
      out_data_r <= {{pcc_pkg::PAD_W{1'b0}}, acc_r, sum_c_r, sum_b_r, sum_a_r};
      out_user_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ===== hdl/polygon_plane_coefficients_core.sv =====
// Plane coefficients of a polygon by Newell's method: top level.
//
// Usage: vertices stream in on the in_ channel, one per transaction, with
// in_tlast on the final vertex of each polygon. One result per polygon leaves
// on the out_ channel: coefficients a, b, c and d in out_tdata and the
// vertex overflow flag in out_tuser.
// Throughput: one vertex per cycle while the queue is not full; after the
// last vertex the back end retires the polygon through the closing edge,
// the sum pipeline and six passes of the single offset multiplier. A
// four-entry vertex queue lets the input keep streaming while the back end
// works on the closing sequence.
// Reset: rst_n low clears the queue, the vertex count, the sums and the
// result valid flag; the next vertex starts a new polygon.
// Stall: a held result blocks only the next result; vertices keep entering
// until the queue fills, then in_tready drops.
`default_nettype none
`include "polygon_plane_coefficients_core_macros.svh"
module polygon_plane_coefficients_core #(
  parameter int COORD_BITS   = pcc_pkg::COORD_BITS_DEF,
  parameter int MAX_VERTICES = pcc_pkg::MAX_VERTICES_DEF,
  parameter int QUEUE_DEPTH  = pcc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // vertex_x, vertex_y, vertex_z
  input  wire logic [pcc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // coef_a, coef_b, coef_c, coef_d, zero fill
  output logic [pcc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // vertex_overflow
  output logic                                 out_tuser
);

  pcc_pkg::vtx_t       push_entry, pop_entry;
  pcc_pkg::back_stat_t bst;
  logic                q_push, q_full, q_valid;

  pcc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  pcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (bst.pop),
    .pop_entry (pop_entry),
    .valid     (q_valid)
  );

  pcc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .stat      (bst),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `PCC_ASSERT_IMP(a_pop_has_data, clk, rst_n, bst.pop, q_valid)
  `PCC_ASSERT_IMP(a_no_pop_when_busy, clk, rst_n, !bst.running, !bst.pop)
  `PCC_ASSERT_IMP(a_emit_into_free_slot, clk, rst_n, bst.emit, !out_tvalid || out_tready)
  `PCC_ASSERT_NXT(a_emit_shows_result, clk, rst_n, bst.emit, out_tvalid)

endmodule
`default_nettype wire
